// ===== rtl/dmbhs_pkg.sv =====
// ----------------------------------------------------------------------------
// dmbhs_pkg
// Shared constants, payload types and controller/datapath link types for the
// menu button hit select block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmbhs_pkg;

  localparam int MAX_BUTTONS = 36;
  localparam int COORD_BITS  = 10;

  localparam int IDX_W  = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam int CNT_W  = $clog2(MAX_BUTTONS + 1);
  localparam int KIND_W = 2;
  localparam int BTN_W  = 6;
  localparam int EVT_W  = 2;
  localparam int PTR_W  = 16;
  localparam int CMP_W  = (CNT_W > BTN_W) ? CNT_W : BTN_W;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int SUM_W  = SQ_W + 1;
  localparam int DIST_W = 28;
  localparam int RECT_W = 4 * COORD_BITS;

  localparam logic [DIST_W-1:0] DIST_BOUND = 28'h800_0000;

  localparam logic [COORD_BITS-1:0] FRAME_W_RESET = COORD_BITS'(720);
  localparam logic [COORD_BITS-1:0] FRAME_H_RESET = COORD_BITS'(576);

  // request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRESS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MOTION = 2'd2;
  localparam logic [KIND_W-1:0] KIND_OTHER  = 2'd3;

  // event codes
  localparam logic [EVT_W-1:0] EV_NONE     = 2'd0;
  localparam logic [EVT_W-1:0] EV_ACTIVATE = 2'd1;
  localparam logic [EVT_W-1:0] EV_SELECT   = 2'd2;

  // configuration register map
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHLIGHT_ACTIVE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_BUTTON   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [5:0]             entry_index;
    logic [COORD_BITS-1:0]  left_edge;
    logic [COORD_BITS-1:0]  right_edge;
    logic [COORD_BITS-1:0]  top_edge;
    logic [COORD_BITS-1:0]  bottom_edge;
    logic signed [PTR_W-1:0] pointer_x;
    logic signed [PTR_W-1:0] pointer_y;
  } in_req_t;

  typedef struct packed {
    logic             handled;
    logic [EVT_W-1:0] event_kind;
    logic [BTN_W-1:0] chosen_button;
  } out_rsp_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] y1;
  } rect_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic out_load;
    logic out_hit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic no_search;
    logic cnt_zero;
    logic issue_last;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE_NONE,
    ST_DONE_HIT
  } ctrl_state_e;

endpackage

// ===== rtl/dmbhs_ram.sv =====
// ----------------------------------------------------------------------------
// dmbhs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmbhs_ram #(
  parameter int  WIDTH  = 40,
  parameter int  DEPTH  = 36,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dmbhs_datapath.sv =====
// ----------------------------------------------------------------------------
// dmbhs_datapath
// Configuration registers, pointer scaling, button table, hit test pipeline,
// nearest centre tracking and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmbhs_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dmbhs_pkg::in_req_t                   in_req_i,
  input  logic                                 cfg_valid_i,
  input  logic [dmbhs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dmbhs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  dmbhs_pkg::ctrl_cmd_t                 cmd_i,
  output dmbhs_pkg::dp_status_t                status_o,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output dmbhs_pkg::out_rsp_t                  out_rsp_o
);

  localparam int C = dmbhs_pkg::COORD_BITS;

  // configuration
  logic [dmbhs_pkg::BTN_W-1:0] count_q;
  logic                        hl_q;
  logic [dmbhs_pkg::BTN_W-1:0] cur_q;
  logic [C-1:0]                fw_q;
  logic [C-1:0]                fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hl_q    <= 1'b0;
      cur_q   <= '0;
      fw_q    <= dmbhs_pkg::FRAME_W_RESET;
      fh_q    <= dmbhs_pkg::FRAME_H_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_i)
        dmbhs_pkg::REG_BUTTON_COUNT:     count_q <= cfg_data_i[dmbhs_pkg::BTN_W-1:0];
        dmbhs_pkg::REG_HIGHLIGHT_ACTIVE: hl_q    <= cfg_data_i[0];
        dmbhs_pkg::REG_CURRENT_BUTTON:   cur_q   <= cfg_data_i[dmbhs_pkg::BTN_W-1:0];
        dmbhs_pkg::REG_FRAME_WIDTH:      fw_q    <= cfg_data_i;
        dmbhs_pkg::REG_FRAME_HEIGHT:     fh_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturated button count
  logic [dmbhs_pkg::CNT_W-1:0] n_sat;
  always_comb begin
    if (dmbhs_pkg::CMP_W'(count_q) > dmbhs_pkg::CMP_W'(dmbhs_pkg::MAX_BUTTONS)) begin
      n_sat = dmbhs_pkg::CNT_W'(dmbhs_pkg::MAX_BUTTONS);
    end else begin
      n_sat = dmbhs_pkg::CNT_W'(count_q);
    end
  end

  // pointer scaling to frame pixels
  logic [15:0]     x_off;
  logic [16:0]     y_off;
  logic [16+C-1:0] prod_x;
  logic [17+C-1:0] prod_y;

  assign x_off  = {~in_req_i.pointer_x[15], in_req_i.pointer_x[14:0]};
  assign y_off  = 17'd32768 - {in_req_i.pointer_y[15], in_req_i.pointer_y};
  assign prod_x = x_off * fw_q;
  assign prod_y = y_off * fh_q;

  logic [C-1:0]                 px_q, py_q;
  logic [dmbhs_pkg::KIND_W-1:0] kind_q;
  logic [dmbhs_pkg::CNT_W-1:0]  n_q;
  logic [dmbhs_pkg::CNT_W-1:0]  cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      px_q   <= prod_x[16+C-1:16];
      py_q   <= prod_y[16+C-1:16];
      kind_q <= in_req_i.kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      cnt_q <= '0;
    end else if (cmd_i.accept) begin
      n_q   <= n_sat;
      cnt_q <= '0;
    end else if (cmd_i.issue) begin
      cnt_q <= cnt_q + dmbhs_pkg::CNT_W'(1);
    end
  end

  // button table
  logic            ram_we;
  dmbhs_pkg::rect_t wr_rect;
  dmbhs_pkg::rect_t rd_rect;
  logic [dmbhs_pkg::RECT_W-1:0] rd_data;

  assign ram_we = cmd_i.accept && (in_req_i.kind == dmbhs_pkg::KIND_LOAD) &&
                  (dmbhs_pkg::CMP_W'(in_req_i.entry_index) <
                   dmbhs_pkg::CMP_W'(dmbhs_pkg::MAX_BUTTONS));
  assign wr_rect = '{x0: in_req_i.left_edge, x1: in_req_i.right_edge,
                     y0: in_req_i.top_edge,  y1: in_req_i.bottom_edge};
  assign rd_rect = dmbhs_pkg::rect_t'(rd_data);

  dmbhs_ram #(
    .WIDTH (dmbhs_pkg::RECT_W),
    .DEPTH (dmbhs_pkg::MAX_BUTTONS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_req_i.entry_index[dmbhs_pkg::IDX_W-1:0]),
    .wdata_i (wr_rect),
    .re_i    (cmd_i.issue),
    .raddr_i (cnt_q[dmbhs_pkg::IDX_W-1:0]),
    .rdata_o (rd_data)
  );

  // stage 1: hit test and centre offsets
  logic                        v1_q, v2_q, v3_q;
  logic [dmbhs_pkg::CNT_W-1:0] b1_q, b2_q, b3_q;
  logic                        hit1, hit2_q, hit3_q;
  logic [C:0]                  sum_x, sum_y;
  logic [C-1:0]                cx, cy, dx1, dy1, dx2_q, dy2_q;
  logic [dmbhs_pkg::SQ_W-1:0]  sqx3_q, sqy3_q;

  assign hit1  = (px_q >= rd_rect.x0) && (px_q <= rd_rect.x1) &&
                 (py_q >= rd_rect.y0) && (py_q <= rd_rect.y1);
  assign sum_x = {1'b0, rd_rect.x0} + {1'b0, rd_rect.x1};
  assign sum_y = {1'b0, rd_rect.y0} + {1'b0, rd_rect.y1};
  assign cx    = sum_x[C:1];
  assign cy    = sum_y[C:1];
  assign dx1   = (cx > px_q) ? (cx - px_q) : (px_q - cx);
  assign dy1   = (cy > py_q) ? (cy - py_q) : (py_q - cy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      b1_q <= cnt_q;
    end
    b2_q   <= b1_q;
    hit2_q <= hit1;
    dx2_q  <= dx1;
    dy2_q  <= dy1;
    b3_q   <= b2_q;
    hit3_q <= hit2_q;
    sqx3_q <= dx2_q * dx2_q;
    sqy3_q <= dy2_q * dy2_q;
  end

  // stage 3: nearest centre, earlier button wins a tie
  logic [dmbhs_pkg::SUM_W-1:0]  dist_sum;
  logic [dmbhs_pkg::DIST_W-1:0] dist_q;
  logic [dmbhs_pkg::CNT_W-1:0]  best_q;

  assign dist_sum = dmbhs_pkg::SUM_W'(sqx3_q) + dmbhs_pkg::SUM_W'(sqy3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= dmbhs_pkg::DIST_BOUND;
      best_q <= '0;
    end else if (cmd_i.accept) begin
      dist_q <= dmbhs_pkg::DIST_BOUND;
      best_q <= '0;
    end else if (v3_q && hit3_q && (dmbhs_pkg::DIST_W'(dist_sum) < dist_q)) begin
      dist_q <= dmbhs_pkg::DIST_W'(dist_sum);
      best_q <= b3_q + dmbhs_pkg::CNT_W'(1);
    end
  end

  // response
  dmbhs_pkg::out_rsp_t rsp_d, out_q;
  logic                out_valid_q;

  always_comb begin
    rsp_d = '0;
    if (cmd_i.out_hit) begin
      rsp_d.handled = 1'b1;
      if (best_q != '0) begin
        rsp_d.chosen_button = dmbhs_pkg::BTN_W'(best_q);
        case (kind_q)
          dmbhs_pkg::KIND_PRESS: rsp_d.event_kind = dmbhs_pkg::EV_ACTIVATE;
          dmbhs_pkg::KIND_MOTION: begin
            if (dmbhs_pkg::CMP_W'(cur_q) == dmbhs_pkg::CMP_W'(best_q)) begin
              rsp_d.event_kind = dmbhs_pkg::EV_NONE;
            end else begin
              rsp_d.event_kind = dmbhs_pkg::EV_SELECT;
            end
          end
          default: rsp_d.event_kind = dmbhs_pkg::EV_NONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign status_o.no_search  = (in_req_i.kind == dmbhs_pkg::KIND_LOAD) || !hl_q;
  assign status_o.cnt_zero   = (n_sat == '0);
  assign status_o.issue_last = ((cnt_q + dmbhs_pkg::CNT_W'(1)) == n_q);
  assign status_o.pipe_busy  = v1_q || v2_q || v3_q;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  a_read_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (cnt_q < n_q))
    else $error("table read beyond button count");

  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_q <= n_q)
    else $error("best button beyond button count");

  a_event_handled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.event_kind != dmbhs_pkg::EV_NONE)) |-> out_q.handled)
    else $error("event reported on unhandled request");

  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.out_load))
    else $error("output valid without a load");

endmodule

// ===== rtl/dmbhs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmbhs_ctrl
// Controller: accepts a request, steps the table walk, waits for the hit
// pipeline to drain and hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmbhs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  dmbhs_pkg::dp_status_t status_i,
  output dmbhs_pkg::ctrl_cmd_t  cmd_o
);

  dmbhs_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmbhs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dmbhs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.no_search) begin
            state_d = dmbhs_pkg::ST_DONE_NONE;
          end else if (status_i.cnt_zero) begin
            state_d = dmbhs_pkg::ST_DONE_HIT;
          end else begin
            state_d = dmbhs_pkg::ST_WALK;
          end
        end
      end
      dmbhs_pkg::ST_WALK: begin
        if (status_i.issue_last) begin
          state_d = dmbhs_pkg::ST_DRAIN;
        end
      end
      dmbhs_pkg::ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = dmbhs_pkg::ST_DONE_HIT;
        end
      end
      dmbhs_pkg::ST_DONE_NONE,
      dmbhs_pkg::ST_DONE_HIT: begin
        if (status_i.out_free) begin
          state_d = dmbhs_pkg::ST_IDLE;
        end
      end
      default: state_d = dmbhs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      dmbhs_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      dmbhs_pkg::ST_WALK: begin
        cmd_o.issue = 1'b1;
      end
      dmbhs_pkg::ST_DONE_NONE: begin
        cmd_o.out_load = status_i.out_free;
      end
      dmbhs_pkg::ST_DONE_HIT: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_hit  = 1'b1;
      end
      default: ;
    endcase
  end

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dmbhs_pkg::ST_IDLE) |-> !status_i.pipe_busy)
    else $error("hit pipeline busy while idle");

  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dmbhs_pkg::ST_DRAIN) |-> !cmd_o.issue)
    else $error("table read issued while draining");

  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q != dmbhs_pkg::ST_IDLE))
    else $error("accepted request left controller idle");

endmodule

// ===== rtl/dvd_menu_button_hit_select_core.sv =====
// ----------------------------------------------------------------------------
// dvd_menu_button_hit_select_core
// Load request, or pointer request with highlight off or no buttons: the
// result goes from the done state into the output register once that is
// free; the next request is taken after it has been loaded.
// Pointer request: the result follows the walk over N table entries, N being
// the saturated button count, read by the one-entry-per-cycle table walk,
// and the drain of its three-stage hit pipeline.
// Reset: asynchronous, active low; configuration returns to its defaults,
// table contents stay undefined until loaded.
`timescale 1ns / 1ps

module dvd_menu_button_hit_select_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  dmbhs_pkg::in_req_t               in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output dmbhs_pkg::out_rsp_t              out_rsp_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dmbhs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dmbhs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  dmbhs_pkg::ctrl_cmd_t  cmd;
  dmbhs_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  dmbhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dmbhs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ===== sim/dmbhs_hit_checker.sv =====
// ----------------------------------------------------------------------------
// dmbhs_hit_checker
// Watches the request, response and configuration channels of the menu
// button hit select core. It keeps its own copy of the button table and of
// the registers, predicts the response to every accepted request and
// compares each accepted response field by field against the oldest
// prediction. It reports the number of outstanding predictions and failures.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmbhs_hit_checker
  import dmbhs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_req_t              in_req_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_rsp_t             out_rsp_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                   pending_o,
  output int                   fail_count_o
);

  rect_t                 btn_tab [MAX_BUTTONS];
  logic [5:0]            btn_count;
  logic                  highlight_on;
  logic [5:0]            cur_btn;
  logic [COORD_BITS-1:0] frame_w;
  logic [COORD_BITS-1:0] frame_h;
  out_rsp_t              hit_rsp_q [$];

  function automatic out_rsp_t hit_select(in_req_t r);
    out_rsp_t rsp;
    int sx, sy, px, py, n, best, best_d, d, mx, my;
    rsp = '0;
    if (r.kind == KIND_LOAD || !highlight_on) return rsp;
    sx = $signed(r.pointer_x);
    sy = $signed(r.pointer_y);
    px = ((32768 + sx) * int'(frame_w)) >>> 16;
    py = ((32768 - sy) * int'(frame_h)) >>> 16;
    n = (int'(btn_count) > MAX_BUTTONS) ? MAX_BUTTONS : int'(btn_count);
    best = 0;
    best_d = int'(DIST_BOUND);
    for (int b = 0; b < n; b++) begin
      if (px >= int'(btn_tab[b].x0) && px <= int'(btn_tab[b].x1) &&
          py >= int'(btn_tab[b].y0) && py <= int'(btn_tab[b].y1)) begin
        mx = (int'(btn_tab[b].x0) + int'(btn_tab[b].x1)) >>> 1;
        my = (int'(btn_tab[b].y0) + int'(btn_tab[b].y1)) >>> 1;
        d = (mx - px) * (mx - px) + (my - py) * (my - py);
        if (d < best_d) begin
          best_d = d;
          best = b + 1;
        end
      end
    end
    rsp.handled = 1'b1;
    if (best == 0) return rsp;
    rsp.chosen_button = BTN_W'(best);
    if (r.kind == KIND_PRESS) begin
      rsp.event_kind = EV_ACTIVATE;
    end else if (r.kind == KIND_MOTION) begin
      rsp.event_kind = (int'(cur_btn) == best) ? EV_NONE : EV_SELECT;
    end else begin
      rsp.event_kind = EV_NONE;
    end
    return rsp;
  endfunction

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_rsp_t exp_rsp;
    if (!rst_ni) begin
      btn_count    = '0;
      highlight_on = 1'b0;
      cur_btn      = '0;
      frame_w      = FRAME_W_RESET;
      frame_h      = FRAME_H_RESET;
      for (int i = 0; i < MAX_BUTTONS; i++) btn_tab[i] = '0;
      hit_rsp_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_i)
          REG_BUTTON_COUNT:     btn_count    = cfg_data_i[5:0];
          REG_HIGHLIGHT_ACTIVE: highlight_on = cfg_data_i[0];
          REG_CURRENT_BUTTON:   cur_btn      = cfg_data_i[5:0];
          REG_FRAME_WIDTH:      frame_w      = cfg_data_i;
          REG_FRAME_HEIGHT:     frame_h      = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (hit_rsp_q.size() == 0) begin
          $error("response with none outstanding: %p", out_rsp_i);
          fail_count_o++;
        end else begin
          exp_rsp = hit_rsp_q.pop_front();
          if (out_rsp_i.handled !== exp_rsp.handled) begin
            $error("handled: expected %0d, actual %0d", exp_rsp.handled, out_rsp_i.handled);
            fail_count_o++;
          end
          if (out_rsp_i.event_kind !== exp_rsp.event_kind) begin
            $error("event_kind: expected %0d, actual %0d",
                   exp_rsp.event_kind, out_rsp_i.event_kind);
            fail_count_o++;
          end
          if (out_rsp_i.chosen_button !== exp_rsp.chosen_button) begin
            $error("chosen_button: expected %0d, actual %0d",
                   exp_rsp.chosen_button, out_rsp_i.chosen_button);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        hit_rsp_q.push_back(hit_select(in_req_i));
        if (in_req_i.kind == KIND_LOAD && int'(in_req_i.entry_index) < MAX_BUTTONS) begin
          btn_tab[in_req_i.entry_index] = '{x0: in_req_i.left_edge, x1: in_req_i.right_edge,
                                            y0: in_req_i.top_edge, y1: in_req_i.bottom_edge};
        end
      end
      pending_o <= hit_rsp_q.size();
    end
  end

endmodule

// ===== sim/tb_dvd_menu_button_hit_select_core.sv =====
// ----------------------------------------------------------------------------
// tb_dvd_menu_button_hit_select_core
// Stimulus and verdict for the menu button hit select core. A short directed
// part covers the edge cases of loading, scaling, ties and event choice; a
// random part then runs several register settings with mostly aimed pointer
// requests and random idling on both channels. Checking is left to the
// hit checker instantiated beside the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dvd_menu_button_hit_select_core;
  import dmbhs_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_req_t               in_req;
  logic                  out_valid;
  logic                  out_stall;
  out_rsp_t              out_rsp;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    pending;
  int                    fail_count;

  // stimulus-side copy of table and scaling, used only to aim the pointer
  rect_t                 aim_tab [MAX_BUTTONS];
  int                    aim_n;
  int                    aim_fw;
  int                    aim_fh;
  logic                  burst;

  dvd_menu_button_hit_select_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  dmbhs_hit_checker u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_rsp_i    (out_rsp),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("dvd_menu_button_hit_select_core test failed");
    $finish;
  end

  function automatic int idle_cycles();
    return burst ? 0 : $urandom_range(0, 17);
  endfunction

  // response side stall
  initial begin : rsp_sink
    int w;
    out_stall = 1'b1;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      w = idle_cycles();
      if (w != 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic rect_t rand_rect();
    rect_t r;
    int    w;
    int    h;
    r = '0;
    case ($urandom_range(0, 9))
      0: r = rect_t'({$urandom(), $urandom()});
      1: begin
        r.x0 = COORD_BITS'($urandom_range(1, 1023));
        r.x1 = COORD_BITS'($urandom_range(0, int'(r.x0) - 1));
        r.y0 = COORD_BITS'($urandom_range(0, 1023));
        r.y1 = COORD_BITS'($urandom_range(int'(r.y0), 1023));
      end
      default: begin
        w    = $urandom_range(0, 400);
        h    = $urandom_range(0, 400);
        r.x0 = COORD_BITS'($urandom_range(0, 1023));
        r.y0 = COORD_BITS'($urandom_range(0, 1023));
        r.x1 = (int'(r.x0) + w > 1023) ? 10'd1023 : COORD_BITS'(int'(r.x0) + w);
        r.y1 = (int'(r.y0) + h > 1023) ? 10'd1023 : COORD_BITS'(int'(r.y0) + h);
      end
    endcase
    return r;
  endfunction

  function automatic rect_t mk_rect(int x0, int x1, int y0, int y1);
    rect_t r;
    r.x0 = COORD_BITS'(x0);
    r.x1 = COORD_BITS'(x1);
    r.y0 = COORD_BITS'(y0);
    r.y1 = COORD_BITS'(y1);
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_from_px(int px);
    int s;
    if (aim_fw == 0) return PTR_W'($urandom());
    s = (px * 65536 + aim_fw - 1) / aim_fw - 32768;
    if (s > 32767) s = 32767;
    return PTR_W'(s);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_from_py(int py);
    int u;
    if (aim_fh == 0) return PTR_W'($urandom());
    u = (py * 65536 + aim_fh - 1) / aim_fh;
    if (u < 1) u = 1;
    if (u > 65536) u = 65536;
    return PTR_W'(32768 - u);
  endfunction

  task automatic send_req(in_req_t r);
    int gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_load(int idx, rect_t b);
    in_req_t r;
    r             = in_req_t'({$urandom(), $urandom(), $urandom()});
    r.kind        = KIND_LOAD;
    r.entry_index = 6'(idx);
    r.left_edge   = b.x0;
    r.right_edge  = b.x1;
    r.top_edge    = b.y0;
    r.bottom_edge = b.y1;
    if (idx < MAX_BUTTONS) aim_tab[idx] = b;
    send_req(r);
  endtask

  task automatic send_pointer(logic [KIND_W-1:0] kind, logic [PTR_W-1:0] x,
                              logic [PTR_W-1:0] y);
    in_req_t r;
    r           = in_req_t'({$urandom(), $urandom(), $urandom()});
    r.kind      = kind;
    r.pointer_x = x;
    r.pointer_y = y;
    send_req(r);
  endtask

  task automatic send_at(logic [KIND_W-1:0] kind, int px, int py);
    send_pointer(kind, ptr_from_px(px), ptr_from_py(py));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (48) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_setup(int count, int hl, int cur, int fw, int fh);
    wait_idle();
    write_reg(REG_BUTTON_COUNT, count);
    write_reg(REG_HIGHLIGHT_ACTIVE, hl);
    write_reg(REG_CURRENT_BUTTON, cur);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    cfg_valid <= 1'b0;
    aim_n  = (count > MAX_BUTTONS) ? MAX_BUTTONS : count;
    aim_fw = fw;
    aim_fh = fh;
  endtask

  initial begin : stim
    int    sel;
    int    b;
    int    px;
    int    py;
    rect_t r;
    logic [KIND_W-1:0] kind;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    cfg_valid = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    burst     = 1'b0;
    aim_n     = 0;
    aim_fw    = 720;
    aim_fh    = 576;
    for (int i = 0; i < MAX_BUTTONS; i++) aim_tab[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // highlight off after reset: pointer requests go unhandled
    send_pointer(KIND_PRESS, 16'h8000, 16'h7fff);
    send_pointer(KIND_MOTION, 16'h7fff, 16'h8000);
    send_pointer(KIND_OTHER, 16'h0000, 16'h0000);
    // loads beyond the table are dropped
    send_load(63, mk_rect(1023, 1023, 1023, 1023));
    send_load(36, mk_rect(0, 0, 0, 0));
    send_load(0, mk_rect(0, 511, 0, 511));
    send_load(1, mk_rect(100, 200, 100, 200));
    send_load(2, mk_rect(300, 200, 0, 1023));
    send_load(3, mk_rect(100, 200, 100, 200));
    send_load(4, mk_rect(512, 1023, 512, 1023));

    apply_setup(5, 1, 2, 1023, 1023);
    send_at(KIND_PRESS, 150, 150);   // tie between equal rectangles
    send_at(KIND_MOTION, 150, 150);  // onto the current button
    send_at(KIND_OTHER, 150, 150);
    send_at(KIND_MOTION, 400, 400);
    send_pointer(KIND_PRESS, 16'h7fff, 16'h8000);
    send_pointer(KIND_PRESS, 16'h8000, 16'h7fff);
    send_at(KIND_PRESS, 250, 600);   // the empty rectangle and entry 4 span this row, neither holds the point
    apply_setup(0, 1, 0, 1023, 1023);
    send_at(KIND_PRESS, 150, 150);

    // fill the whole table before any walk can reach it
    for (int i = 0; i < MAX_BUTTONS; i++) send_load(i, rand_rect());

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_setup(36, 1, 0, 1023, 1023);
        1: apply_setup(63, 1, 36, 720, 576);
        2: apply_setup(0, 1, 5, 1023, 0);
        3: apply_setup(1, 1, 1, 0, 1023);
        4: apply_setup($urandom_range(0, 36), 0, $urandom_range(0, 36),
                       $urandom_range(0, 1023), $urandom_range(0, 1023));
        5: apply_setup(40, 1, $urandom_range(0, 36), 1, 1);
        6: apply_setup($urandom_range(0, 36), 1, $urandom_range(0, 36),
                       $urandom_range(0, 1023), $urandom_range(0, 1023));
        default: apply_setup(36, 1, $urandom_range(0, 36), 1023, 1023);
      endcase
      burst = (p == 3 || p == 6);
      for (int i = 0; i < 105; i++) begin
        sel  = $urandom_range(0, 99);
        kind = KIND_W'($urandom_range(1, 3));
        if (sel < 15) begin
          send_load($urandom_range(0, 63), rand_rect());
        end else if (sel < 85 && aim_n > 0) begin
          b  = $urandom_range(0, aim_n - 1);
          r  = aim_tab[b];
          px = (r.x0 <= r.x1) ? $urandom_range(int'(r.x0), int'(r.x1)) : $urandom_range(0, 1023);
          py = (r.y0 <= r.y1) ? $urandom_range(int'(r.y0), int'(r.y1)) : $urandom_range(0, 1023);
          send_at(kind, px, py);
        end else begin
          send_pointer(kind, PTR_W'($urandom()), PTR_W'($urandom()));
        end
      end
      burst = 1'b0;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("dvd_menu_button_hit_select_core test passed");
    end else begin
      $display("dvd_menu_button_hit_select_core test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dmbhs_pkg.sv
rtl/dmbhs_ram.sv
rtl/dmbhs_datapath.sv
rtl/dmbhs_ctrl.sv
rtl/dvd_menu_button_hit_select_core.sv
sim/dmbhs_hit_checker.sv
sim/tb_dvd_menu_button_hit_select_core.sv
